FILE: sv/tswsc_pkg.sv
// Shared types, character constants and class codes for the text counter.
package tswsc_pkg;

	// Default width of the sentence, word and syllable totals.
	localparam int unsigned COUNT_WIDTH_DEF = 32;

	// Width of the result fields on the output channel.
	localparam int unsigned OUT_WIDTH = 32;

	// Width of the syllable count of the word that is still open.
	localparam int unsigned PEND_WIDTH = 16;

	// Character codes the classifier looks for, after folding to upper case.
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_E     = 8'h45;
	localparam logic [7:0] CH_I     = 8'h49;
	localparam logic [7:0] CH_M     = 8'h4D;
	localparam logic [7:0] CH_O     = 8'h4F;
	localparam logic [7:0] CH_U     = 8'h55;
	localparam logic [7:0] CH_Y     = 8'h59;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_QUEST = 8'h3F;
	localparam logic [7:0] CH_EOF   = 8'hFF;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;
	localparam logic [7:0] CASE_OFS = 8'h20;

	// Character classes. START only appears as the previous class of a fresh text.
	typedef enum logic [2:0] {
		CLS_START = 3'd0,
		CLS_VOWEL = 3'd1,
		CLS_OTHER = 3'd2,
		CLS_E     = 3'd3,
		CLS_SEP   = 3'd4
	} char_cls_t;

	// What the classifier tells the counting logic about one byte.
	typedef struct packed {
		char_cls_t cls;
		logic      is_term;
		logic      is_m;
		logic      is_eof;
		logic      is_nul;
	} char_info_t;

endpackage

FILE: sv/tswsc_text_if.sv
// Valid/ready channel that carries one text byte per request.
interface tswsc_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

FILE: sv/tswsc_count_if.sv
// Valid/ready channel that carries the totals of one finished text per request.
interface tswsc_count_if;
	logic                               valid;
	logic                               ready;
	logic [tswsc_pkg::OUT_WIDTH-1:0]    sentence_count;
	logic [tswsc_pkg::OUT_WIDTH-1:0]    word_count;
	logic [tswsc_pkg::OUT_WIDTH-1:0]    syllable_count;

	modport source (output valid, output sentence_count, output word_count,
		output syllable_count, input ready);
	modport sink   (input valid, input sentence_count, input word_count,
		input syllable_count, output ready);
endinterface

FILE: sv/tswsc_classify.sv
// Case folding and character classification of one text byte.
module tswsc_classify (
	input  logic [7:0]            text_byte,
	input  logic                  end_of_text,
	output tswsc_pkg::char_info_t info
);

	logic       eof;
	logic [7:0] ch;

	assign eof = end_of_text || (text_byte == tswsc_pkg::CH_EOF);

	always_comb begin
		if (eof) begin
			ch = tswsc_pkg::CH_EOF;
		end else if (text_byte >= tswsc_pkg::CH_LO_A && text_byte <= tswsc_pkg::CH_LO_Z) begin
			ch = text_byte - tswsc_pkg::CASE_OFS;
		end else begin
			ch = text_byte;
		end
	end

	always_comb begin
		if (eof) begin
			info.cls = tswsc_pkg::CLS_OTHER;
		end else if (ch == tswsc_pkg::CH_A || ch == tswsc_pkg::CH_I || ch == tswsc_pkg::CH_O
				|| ch == tswsc_pkg::CH_U || ch == tswsc_pkg::CH_Y) begin
			info.cls = tswsc_pkg::CLS_VOWEL;
		end else if (ch == tswsc_pkg::CH_E) begin
			info.cls = tswsc_pkg::CLS_E;
		end else if (ch == tswsc_pkg::CH_SPACE || ch == tswsc_pkg::CH_LF
				|| ch == tswsc_pkg::CH_COMMA || ch == tswsc_pkg::CH_NUL
				|| ch == tswsc_pkg::CH_DOT || ch == tswsc_pkg::CH_BANG
				|| ch == tswsc_pkg::CH_QUEST) begin
			info.cls = tswsc_pkg::CLS_SEP;
		end else begin
			info.cls = tswsc_pkg::CLS_OTHER;
		end
		info.is_term = (ch == tswsc_pkg::CH_DOT) || (ch == tswsc_pkg::CH_BANG)
			|| (ch == tswsc_pkg::CH_QUEST);
		info.is_m    = (ch == tswsc_pkg::CH_M);
		info.is_eof  = eof;
		info.is_nul  = !eof && (ch == tswsc_pkg::CH_NUL);
	end

endmodule

FILE: sv/text_syllable_word_sentence_counter_unit.sv
// Top level of the text syllable, word and sentence counter.
//
//   channel    | modport | payload                                    | per request
//   -----------+---------+--------------------------------------------+----------------------
//   text_in    | sink    | text_byte[7:0], end_of_text                | one byte of text
//   count_out  | source  | sentence_count, word_count, syllable_count | totals of one text
//
// A byte is taken into the input stage when its request is accepted and is counted from there;
// a text's totals are loaded into the result register as its ending byte leaves the input
// stage, and are offered on count_out from then on.
// One byte per cycle is sustained through the single register stage before the counters,
// except while the input stage stalls. The input stage stalls only when an ending byte meets a
// result register that still holds totals not yet taken. arst_n clears all valid flags,
// the previous class and every counter at once; no clearing pass follows reset.
module text_syllable_word_sentence_counter_unit #(
	parameter int unsigned COUNT_WIDTH = tswsc_pkg::COUNT_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	tswsc_text_if.sink        text_in,
	tswsc_count_if.source     count_out
);

	localparam int unsigned PW = tswsc_pkg::PEND_WIDTH;
	localparam int unsigned OW = tswsc_pkg::OUT_WIDTH;

	// Input stage: the request as it arrived.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eot_s1;

	// Running state of the current text.
	tswsc_pkg::char_cls_t     prev_cls_q;
	logic [PW-1:0]            pend_q;
	logic [COUNT_WIDTH-1:0]   sent_q;
	logic [COUNT_WIDTH-1:0]   word_q;
	logic [COUNT_WIDTH-1:0]   syl_q;

	// Result register.
	logic          out_valid_q;
	logic [OW-1:0] out_sent_q;
	logic [OW-1:0] out_word_q;
	logic [OW-1:0] out_syl_q;

	tswsc_pkg::char_info_t info;

	logic                   done;
	logic                   s1_fire;
	logic                   syl_inc;
	logic                   word_close;
	logic                   sent_inc;
	logic [PW-1:0]          pend_inc;
	logic [COUNT_WIDTH:0]   sent_sum;
	logic [COUNT_WIDTH:0]   word_sum;
	logic [COUNT_WIDTH:0]   syl_sum;
	logic [COUNT_WIDTH-1:0] sent_n;
	logic [COUNT_WIDTH-1:0] word_n;
	logic [COUNT_WIDTH-1:0] syl_n;
	logic [PW-1:0]          pend_n;

	tswsc_classify u_classify (
		.text_byte   (byte_s1),
		.end_of_text (eot_s1),
		.info        (info)
	);

	// A text ends on NUL, on byte 255 or on the end_of_text flag.
	assign done = info.is_eof || info.is_nul;

	// The staged byte moves on unless it has totals to deliver and the result
	// register is still occupied.
	assign s1_fire       = valid_s1 && (!done || !out_valid_q || count_out.ready);
	assign text_in.ready = !valid_s1 || s1_fire;

	// Syllable rule: the pending count rises on a vowel followed by an other-class byte or a
	// separator, on an E followed by an other-class byte, and on an M after an other-class byte.
	assign syl_inc = (prev_cls_q == tswsc_pkg::CLS_VOWEL
			&& (info.cls == tswsc_pkg::CLS_OTHER || info.cls == tswsc_pkg::CLS_SEP))
		|| (prev_cls_q == tswsc_pkg::CLS_E && info.cls == tswsc_pkg::CLS_OTHER)
		|| (prev_cls_q == tswsc_pkg::CLS_OTHER && info.is_m);

	assign pend_inc = (syl_inc && pend_q != {PW{1'b1}}) ? pend_q + PW'(1) : pend_q;

	// A separator after a byte that is not a separator closes a word; the open word's syllables,
	// including any counted on this very byte, move into the total.
	assign word_close = prev_cls_q != tswsc_pkg::CLS_START
		&& prev_cls_q != tswsc_pkg::CLS_SEP && info.cls == tswsc_pkg::CLS_SEP;

	// A terminator right after a separator does not open a new sentence.
	assign sent_inc = info.is_term && prev_cls_q != tswsc_pkg::CLS_SEP;

	// Saturating totals: one spare bit catches the carry out.
	assign sent_sum = {1'b0, sent_q} + (COUNT_WIDTH+1)'(1);
	assign word_sum = {1'b0, word_q} + (COUNT_WIDTH+1)'(1);
	assign syl_sum  = {1'b0, syl_q} + (COUNT_WIDTH+1)'(pend_inc);

	always_comb begin
		sent_n = sent_q;
		word_n = word_q;
		syl_n  = syl_q;
		pend_n = pend_inc;
		if (sent_inc) begin
			sent_n = sent_sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sent_sum[COUNT_WIDTH-1:0];
		end
		if (word_close) begin
			word_n = word_sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : word_sum[COUNT_WIDTH-1:0];
			syl_n  = syl_sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : syl_sum[COUNT_WIDTH-1:0];
			pend_n = '0;
		end
	end

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_in.ready) begin
			valid_s1 <= text_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_in.ready && text_in.valid) begin
			byte_s1 <= text_in.text_byte;
			eot_s1  <= text_in.end_of_text;
		end
	end

	// Text state: updated by every byte, cleared when a text ends.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_cls_q <= tswsc_pkg::CLS_START;
			pend_q     <= '0;
			sent_q     <= '0;
			word_q     <= '0;
			syl_q      <= '0;
		end else if (s1_fire) begin
			if (done) begin
				prev_cls_q <= tswsc_pkg::CLS_START;
				pend_q     <= '0;
				sent_q     <= '0;
				word_q     <= '0;
				syl_q      <= '0;
			end else begin
				prev_cls_q <= info.cls;
				pend_q     <= pend_n;
				sent_q     <= sent_n;
				word_q     <= word_n;
				syl_q      <= syl_n;
			end
		end
	end

	// Result register: loaded with the totals of a finished text.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && done) begin
			out_valid_q <= 1'b1;
		end else if (count_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && done) begin
			out_sent_q <= OW'(sent_n);
			out_word_q <= OW'(word_n);
			out_syl_q  <= OW'(syl_n);
		end
	end

	assign count_out.valid          = out_valid_q;
	assign count_out.sentence_count = out_sent_q;
	assign count_out.word_count     = out_word_q;
	assign count_out.syllable_count = out_syl_q;

endmodule
